FILE: rtl/core/jts_pkg.sv
`timescale 1ns / 1ps

package jts_pkg;

  localparam logic [2:0] KIND_PUNCT  = 3'd0;
  localparam logic [2:0] KIND_IDENT  = 3'd1;
  localparam logic [2:0] KIND_NUMBER = 3'd2;
  localparam logic [2:0] KIND_STRING = 3'd3;
  localparam logic [2:0] KIND_REGEX  = 3'd4;
  localparam logic [2:0] KIND_DIVIDE = 3'd5;
  localparam logic [2:0] KIND_ERROR  = 3'd6;

  // event queue between scanner and output stage; power of two
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] chr;
    logic [7:0] len;
  } event_t;

  // all token events caused by one byte; ev0 always present
  typedef struct packed {
    event_t ev0;
    event_t ev1;
    logic   has1;
  } rec_t;

  typedef struct packed {
    logic push;
    logic halted;
  } front_stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) ||
           (c == "$") || (c == "_") || is_digit(c);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    logic r;
    case (c)
      ".", "{", "}", "[", "]", ",", ";", "*", "+", "-", "=", "!", "&", "|",
      "(", ")", ":", "?", "<", ">", "%", "^": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] return_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0: r = "r";
      3'd1: r = "e";
      3'd2: r = "t";
      3'd3: r = "u";
      3'd4: r = "r";
      3'd5: r = "n";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/javascript_token_scanner.sv
`timescale 1ns / 1ps
// Channel   Transfer on                 Payload
// input     in_valid_i && in_ready_o    char_in_i
// output    out_valid_o && out_ready_i  token_kind_o, token_char_o, token_length_o,
//                                       last_of_run_o
//
// One byte per cycle is taken while the four-entry event queue has room.
// A byte yields zero, one or two token events; the output stage sends one
// event per cycle while out_ready_i is high, so two events of a byte leave in turn.
// A byte's first event passes through the queue memory, then the output register.
// Reset clears scanner state, queue and output stage. After an error event
// bytes are still transferred and dropped until reset.
module javascript_token_scanner #(
  parameter int unsigned MAX_TOKEN_LEN = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] token_kind_o,
  output logic [7:0] token_char_o,
  output logic [7:0] token_length_o,
  output logic       last_of_run_o
);
  import jts_pkg::*;

  logic              accept;
  rec_t              front_rec;
  front_stat_t       front_stat;
  rec_t              head_rec;
  logic              q_empty, q_full, q_pop;
  logic [QCNT_W-1:0] q_count;
  event_t            out_ev;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  jts_front #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .char_i  (char_in_i),
    .rec_o   (front_rec),
    .stat_o  (front_stat)
  );

  jts_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_stat.push),
    .rec_i  (front_rec),
    .pop_i  (q_pop),
    .rec_o  (head_rec),
    .empty_o(q_empty),
    .full_o (q_full),
    .count_o(q_count)
  );

  jts_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec_i      (head_rec),
    .empty_i    (q_empty),
    .pop_o      (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .ev_o       (out_ev),
    .last_o     (last_of_run_o)
  );

  assign token_kind_o   = out_ev.kind;
  assign token_char_o   = out_ev.chr;
  assign token_length_o = out_ev.len;

`ifndef SYNTHESIS
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_stat.halted |-> !front_stat.push)
    else $error("event pushed after halt");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_stat.push |-> !q_full)
    else $error("push into full queue");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && !front_stat.push) |=> q_count == $past(q_count) - 1'b1)
    else $error("queue count not reduced on pop");
`endif

endmodule

FILE: rtl/core/jts_front.sv
`timescale 1ns / 1ps

module jts_front #(
  parameter int unsigned MAX_TOKEN_LEN = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            char_i,
  output jts_pkg::rec_t         rec_o,
  output jts_pkg::front_stat_t  stat_o
);
  import jts_pkg::*;

  localparam logic [3:0] M_IDLE   = 4'd0;
  localparam logic [3:0] M_IDENT  = 4'd1;
  localparam logic [3:0] M_NUMBER = 4'd2;
  localparam logic [3:0] M_STRING = 4'd3;
  localparam logic [3:0] M_SLASH  = 4'd4;
  localparam logic [3:0] M_REGEX  = 4'd5;
  localparam logic [3:0] M_BLOCK  = 4'd6;
  localparam logic [3:0] M_LINE   = 4'd7;
  localparam logic [3:0] M_HALT   = 4'd8;

  localparam logic [2:0] P_NONE   = 3'd0;
  localparam logic [2:0] P_PUNCT  = 3'd1;
  localparam logic [2:0] P_CLOSE  = 3'd2;
  localparam logic [2:0] P_IDENT  = 3'd3;
  localparam logic [2:0] P_NUMBER = 3'd4;
  localparam logic [2:0] P_STRING = 3'd5;
  localparam logic [2:0] P_REGEX  = 3'd6;

  localparam logic [2:0] RM_FULL     = 3'd6;
  localparam logic [2:0] RM_MISMATCH = 3'd7;
  localparam logic [7:0] RUN_MAX     = 8'(MAX_TOKEN_LEN);

  logic [3:0] mode_q, mode_d;
  logic       dq_q, dq_d;
  logic       esc_q, esc_d;
  logic [2:0] prev_q, prev_d;
  logic [7:0] run_q, run_d;
  logic [2:0] rm_q, rm_d;

  logic [7:0] c;
  logic [7:0] run_inc;
  logic [7:0] quote_c;
  logic       do_idle;
  logic       lead;
  logic       has0;
  event_t     lead_ev;
  event_t     idle_ev;
  logic       idle_emit;
  rec_t       rec;

  assign c       = char_i;
  assign run_inc = (run_q < RUN_MAX) ? run_q + 8'd1 : run_q;
  assign quote_c = dq_q ? 8'h22 : 8'h27;

  // scan of one byte from idle, independent of state
  always_comb begin
    idle_emit = 1'b0;
    idle_ev   = '{kind: KIND_PUNCT, chr: c, len: 8'd0};
    if (c != "/" && is_punct(c)) begin
      idle_emit = 1'b1;
    end else if (c != "/" && !is_space(c) && c != 8'h27 && c != 8'h22 && !is_ident(c)) begin
      idle_emit    = 1'b1;
      idle_ev.kind = KIND_ERROR;
    end
  end

  always_comb begin
    mode_d  = mode_q;
    dq_d    = dq_q;
    esc_d   = esc_q;
    prev_d  = prev_q;
    run_d   = run_q;
    rm_d    = rm_q;
    do_idle = 1'b0;
    lead    = 1'b0;
    lead_ev = '{kind: KIND_IDENT, chr: 8'd0, len: run_q};

    case (mode_q)
      M_IDLE: do_idle = 1'b1;
      M_IDENT: begin
        if (is_ident(c)) begin
          run_d = run_inc;
          if (rm_q < RM_FULL) begin
            rm_d = (c == return_char(rm_q)) ? rm_q + 3'd1 : RM_MISMATCH;
          end
        end else begin
          lead    = 1'b1;
          do_idle = 1'b1;
        end
      end
      M_NUMBER: begin
        if (is_digit(c) || c == ".") begin
          run_d = run_inc;
        end else begin
          lead         = 1'b1;
          lead_ev.kind = KIND_NUMBER;
          do_idle      = 1'b1;
        end
      end
      M_STRING: begin
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (c == quote_c) begin
          lead         = 1'b1;
          lead_ev.kind = KIND_STRING;
          lead_ev.len  = 8'd0;
          mode_d       = M_IDLE;
        end else if (c == "\\") begin
          esc_d = 1'b1;
        end
      end
      M_SLASH: begin
        if (c == "*") begin
          mode_d = M_BLOCK;
          esc_d  = 1'b0;
        end else if (c == "/") begin
          mode_d = M_LINE;
        end else if ((prev_q != P_NUMBER && prev_q != P_IDENT && prev_q != P_CLOSE) ||
                     (prev_q == P_IDENT && rm_q == RM_FULL)) begin
          mode_d = M_REGEX;
          esc_d  = (c == "\\");
        end else begin
          lead         = 1'b1;
          lead_ev.kind = KIND_DIVIDE;
          lead_ev.len  = 8'd0;
          prev_d       = P_PUNCT;
          do_idle      = 1'b1;
        end
      end
      M_REGEX: begin
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (c == "\\") begin
          esc_d = 1'b1;
        end else if (c == "/") begin
          lead         = 1'b1;
          lead_ev.kind = KIND_REGEX;
          lead_ev.len  = 8'd0;
          prev_d       = P_REGEX;
          mode_d       = M_IDLE;
        end
      end
      M_BLOCK: begin
        if (c == "*") begin
          esc_d = 1'b1;
        end else if (esc_q && c == "/") begin
          esc_d  = 1'b0;
          mode_d = M_IDLE;
        end else begin
          esc_d = 1'b0;
        end
      end
      M_LINE: begin
        if (c == 8'h0a || c == 8'h0d) mode_d = M_IDLE;
      end
      default: mode_d = M_HALT;
    endcase

    if (do_idle) begin
      mode_d = M_IDLE;
      if (c == "/") begin
        mode_d = M_SLASH;
      end else if (is_punct(c)) begin
        prev_d = (c == ")") ? P_CLOSE : P_PUNCT;
      end else if (is_space(c)) begin
        mode_d = M_IDLE;
      end else if (c == 8'h27 || c == 8'h22) begin
        mode_d = M_STRING;
        dq_d   = (c == 8'h22);
        esc_d  = 1'b0;
        prev_d = P_STRING;
      end else if (is_digit(c)) begin
        mode_d = M_NUMBER;
        prev_d = P_NUMBER;
        run_d  = 8'd1;
      end else if (is_ident(c)) begin
        mode_d = M_IDENT;
        prev_d = P_IDENT;
        run_d  = 8'd1;
        rm_d   = (c == "r") ? 3'd1 : RM_MISMATCH;
      end else begin
        mode_d = M_HALT;
      end
    end

    rec      = '{ev0: lead_ev, ev1: idle_ev, has1: 1'b0};
    has0     = lead;
    if (do_idle && idle_emit) begin
      if (lead) begin
        rec.has1 = 1'b1;
      end else begin
        rec.ev0 = idle_ev;
        has0    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      dq_q   <= 1'b0;
      esc_q  <= 1'b0;
      prev_q <= P_NONE;
      run_q  <= 8'd0;
      rm_q   <= RM_MISMATCH;
    end else if (accept_i) begin
      mode_q <= mode_d;
      dq_q   <= dq_d;
      esc_q  <= esc_d;
      prev_q <= prev_d;
      run_q  <= run_d;
      rm_q   <= rm_d;
    end
  end

  assign rec_o         = rec;
  assign stat_o.push   = accept_i && has0;
  assign stat_o.halted = (mode_q == M_HALT);

endmodule

FILE: rtl/core/jts_queue.sv
`timescale 1ns / 1ps

module jts_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  jts_pkg::rec_t               rec_i,
  input  logic                        pop_i,
  output jts_pkg::rec_t               rec_o,
  output logic                        empty_o,
  output logic                        full_o,
  output logic [jts_pkg::QCNT_W-1:0]  count_o
);
  import jts_pkg::*;

  rec_t              mem_q [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rec_o   = mem_q[rd_q];
  assign count_o = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/core/jts_back.sv
`timescale 1ns / 1ps

module jts_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jts_pkg::rec_t     rec_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output jts_pkg::event_t   ev_o,
  output logic              last_o
);
  import jts_pkg::*;

  logic   valid_q;
  logic   pend_q;
  event_t ev_q;
  event_t pend_ev_q;
  logic   last_q;
  logic   slot_free;

  assign slot_free   = !valid_q || out_ready_i;
  assign pop_o       = slot_free && !pend_q && !empty_i;
  assign out_valid_o = valid_q;
  assign ev_o        = ev_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (slot_free) begin
      if (pend_q) begin
        valid_q <= 1'b1;
        pend_q  <= 1'b0;
      end else if (!empty_i) begin
        valid_q <= 1'b1;
        pend_q  <= rec_i.has1;
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      if (pend_q) begin
        ev_q   <= pend_ev_q;
        last_q <= 1'b1;
      end else if (!empty_i) begin
        ev_q      <= rec_i.ev0;
        last_q    <= !rec_i.has1;
        pend_ev_q <= rec_i.ev1;
      end
    end
  end

endmodule
